[hw/rtl/heap_block_allocator_assert.svh]
// Assertion macros shared by the heap allocator RTL.
// Every macro samples on clk and is disabled while rst is high.
`ifndef HEAP_BLOCK_ALLOCATOR_ASSERT_SVH
`define HEAP_BLOCK_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HBA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HBA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/hba_pkg.sv]
// Shared types and constants of the heap block allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`default_nettype none

package hba_pkg;

  localparam int DEF_FREE_ENTRIES = 64;
  localparam int DEF_USED_ENTRIES = 64;
  localparam int DEF_ADDR_BITS    = 32;

  localparam logic [7:0] HDR_RESET = 8'd24;

  // Configuration register indexes.
  localparam logic CFG_FIT_MODE = 1'b0;
  localparam logic CFG_HEADER   = 1'b1;

  // Request functions.
  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  // Fit modes.
  localparam logic FIT_FIRST = 1'b0;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_EXHAUSTED = 2'd3;

  // Table scan kinds.
  localparam logic [1:0] SCAN_ALLOC = 2'd0;
  localparam logic [1:0] SCAN_USED  = 2'd1;
  localparam logic [1:0] SCAN_FREE  = 2'd2;

  typedef struct packed {
    logic       load;
    logic       scan_init;
    logic       scan_step;
    logic [1:0] scan_kind;
    logic       grow;
    logic       split;
    logic       take;
    logic       used_add;
    logic       rel_init;
    logic       merge_write;
    logic       total_add;
    logic       dn_init;
    logic       dn_step;
    logic       dn_used;
    logic       up_init;
    logic       up_step;
    logic       ins;
    logic       finish;
    logic [1:0] fin_status;
  } hba_cmd_t;

  typedef struct packed {
    logic func;
    logic used_full;
    logic hdr_over;
    logic scan_done;
    logic scan_stop;
    logic found;
    logic overflow;
    logic split_fit;
    logic mp;
    logic mn;
    logic free_full;
    logic dn_last;
    logic up_last;
  } hba_stat_t;

endpackage

`default_nettype wire

[hw/rtl/hba_datapath.sv]
// Datapath of the heap block allocator: free and used tables, counters,
// heap top, free total and configuration. Depends on hba_pkg and the assert macros.
`default_nettype none
`include "heap_block_allocator_assert.svh"

module hba_datapath
  import hba_pkg::*;
#(
  parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
  parameter int USED_ENTRIES = DEF_USED_ENTRIES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire hba_cmd_t    cmd,
  output hba_stat_t        st,
  input  wire logic        func,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] release_address,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic [31:0]      data_address,
  output logic [1:0]       status,
  output logic [31:0]      heap_bytes,
  output logic [31:0]      free_bytes
);

  localparam int A   = ADDR_BITS;
  localparam int W   = ((A > 32) ? A : 32) + 2;
  localparam int FCW = $clog2(FREE_ENTRIES + 1);
  localparam int FIW = $clog2(FREE_ENTRIES);
  localparam int UCW = $clog2(USED_ENTRIES + 1);
  localparam int UIW = $clog2(USED_ENTRIES);
  localparam int SW  = (FCW > UCW) ? FCW : UCW;

  // Tables: each entry packs {start, length}.
  logic [2*A-1:0] fmem [FREE_ENTRIES];
  logic [2*A-1:0] umem [USED_ENTRIES];
  logic [2*A-1:0] fq, uq;
  logic [FIW-1:0] f_ra, f_wa;
  logic [UIW-1:0] u_ra, u_wa;
  logic [2*A-1:0] f_wd, u_wd;
  logic           f_we, u_we;

  logic           fit_mode;
  logic [7:0]     header;
  logic           func_r;
  logic [31:0]    req;
  logic [31:0]    raddr;
  logic [FCW-1:0] fcount;
  logic [UCW-1:0] ucount;
  logic [A-1:0]   heap_top;
  logic [A-1:0]   free_total;

  logic [SW-1:0]  scan_idx;
  logic           pend;
  logic           found;
  // Wide enough to point one past a full free table.
  logic [SW-1:0]  hit_idx;
  logic [SW-1:0]  hit_prev;
  logic [UIW-1:0] u_idx;
  logic [A-1:0]   cand_start, cand_len;
  logic [A-1:0]   prev_start, prev_len;
  logic [W-1:0]   rstart;
  logic [A-1:0]   start_r, len_r;
  logic [SW-1:0]  sidx;
  logic           spend;

  logic [W-1:0]   hw, reqw, req_h;
  logic [A-1:0]   fq_start, fq_len, uq_start, uq_len, qs, ql, nbest;
  logic [SW-1:0]  cnt_k, scan_prev;
  logic           cand, nfound, stop, idx_ge, scan_done;
  logic [SW-1:0]  dn_cnt, dn_s2, dn_rd, up_s2, up_rd;
  logic           dn_issue, up_issue;
  logic [W-1:0]   top_grow, split_start, split_len, ft_split, ft_take, ft_add;
  logic [W-1:0]   mp_sum, mn_sum, len_both, len_prev, len_next, addr_sum;
  logic [W-1:0]   addr_wide, top_wide, total_wide;
  logic           mp, mn;

  assign hw    = W'(header);
  assign reqw  = W'(req);
  assign req_h = reqw + hw;

  assign fq_start = fq[2*A-1:A];
  assign fq_len   = fq[A-1:0];
  assign uq_start = uq[2*A-1:A];
  assign uq_len   = uq[A-1:0];
  assign qs       = (cmd.scan_kind == SCAN_USED) ? uq_start : fq_start;
  assign ql       = (cmd.scan_kind == SCAN_USED) ? uq_len : fq_len;
  assign cnt_k    = (cmd.scan_kind == SCAN_USED) ? SW'(ucount) : SW'(fcount);
  assign scan_prev = scan_idx - 1'b1;
  assign hit_prev  = hit_idx - 1'b1;

  // Table scan: pend says fq/uq holds the entry at scan_idx - 1.
  assign cand   = pend && (W'(ql) >= reqw) && (!found || (ql < cand_len));
  assign nfound = found | cand;
  assign nbest  = cand ? ql : cand_len;

  always_comb begin
    case (cmd.scan_kind)
      SCAN_ALLOC: stop = pend && ((cand && (fit_mode == FIT_FIRST)) ||
                                  (nfound && (W'(nbest) <= req_h)));
      SCAN_USED:  stop = pend && (W'(qs) == rstart);
      SCAN_FREE:  stop = pend && (W'(qs) >= rstart);
      default:    stop = 1'b0;
    endcase
  end

  assign idx_ge    = scan_idx >= cnt_k;
  assign scan_done = stop || (!pend && idx_ge);

  // Shift passes: read one entry ahead, write it one slot over next cycle.
  assign dn_cnt   = cmd.dn_used ? SW'(ucount) : SW'(fcount);
  assign dn_s2    = spend ? sidx + 1'b1 : sidx;
  assign dn_rd    = dn_s2 + 1'b1;
  assign dn_issue = dn_rd < dn_cnt;
  assign up_s2    = spend ? sidx - 1'b1 : sidx;
  assign up_rd    = up_s2 - 1'b1;
  assign up_issue = up_s2 > hit_idx;

  assign top_grow    = W'(heap_top) + hw + reqw;
  assign split_start = W'(cand_start) + hw + reqw;
  assign split_len   = W'(cand_len) - reqw - hw;
  assign ft_split    = W'(free_total) - reqw - hw;
  assign ft_take     = W'(free_total) - W'(cand_len) - hw;
  assign ft_add      = W'(free_total) + W'(len_r) + hw;
  assign mp_sum      = W'(prev_start) + W'(prev_len) + hw;
  assign mn_sum      = rstart + W'(len_r) + hw;
  assign len_both    = W'(prev_len) + hw + W'(len_r) + hw + W'(cand_len);
  assign len_prev    = W'(prev_len) + hw + W'(len_r);
  assign len_next    = W'(len_r) + hw + W'(cand_len);
  assign addr_sum    = W'(start_r) + hw;
  assign addr_wide   = W'(addr_sum[A-1:0]);
  assign top_wide    = W'(heap_top);
  assign total_wide  = W'(free_total);

  assign mp = (hit_idx != '0) && (mp_sum == rstart);
  assign mn = found && (mn_sum == W'(cand_start));

  always_comb begin
    st.func      = func_r;
    st.used_full = ucount >= UCW'(USED_ENTRIES);
    st.hdr_over  = W'(raddr) < hw;
    st.scan_done = scan_done;
    st.scan_stop = stop;
    st.found     = found;
    st.overflow  = |top_grow[W-1:A];
    st.split_fit = W'(cand_len) > req_h;
    st.mp        = mp;
    st.mn        = mn;
    st.free_full = fcount >= FCW'(FREE_ENTRIES);
    st.dn_last   = !dn_issue;
    st.up_last   = !up_issue;
  end

  // Memory ports.
  always_comb begin
    f_ra = scan_idx[FIW-1:0];
    if (cmd.dn_step) begin
      f_ra = dn_rd[FIW-1:0];
    end else if (cmd.up_step) begin
      f_ra = up_rd[FIW-1:0];
    end
    u_ra = cmd.dn_step ? dn_rd[UIW-1:0] : scan_idx[UIW-1:0];
  end

  always_comb begin
    f_we = 1'b0;
    f_wa = hit_idx[FIW-1:0];
    f_wd = {fq_start, fq_len};
    if (cmd.split) begin
      f_we = 1'b1;
      f_wd = {split_start[A-1:0], split_len[A-1:0]};
    end else if (cmd.merge_write) begin
      f_we = 1'b1;
      if (mp) begin
        f_wa = hit_prev[FIW-1:0];
        f_wd = {prev_start, mn ? len_both[A-1:0] : len_prev[A-1:0]};
      end else begin
        f_wd = {rstart[A-1:0], len_next[A-1:0]};
      end
    end else if ((cmd.dn_step && !cmd.dn_used) || cmd.up_step) begin
      f_we = spend;
      f_wa = sidx[FIW-1:0];
    end else if (cmd.ins) begin
      f_we = 1'b1;
      f_wd = {rstart[A-1:0], len_r};
    end
  end

  always_comb begin
    u_we = 1'b0;
    u_wa = ucount[UIW-1:0];
    u_wd = {start_r, len_r};
    if (cmd.used_add) begin
      u_we = 1'b1;
    end else if (cmd.dn_step && cmd.dn_used) begin
      u_we = spend;
      u_wa = sidx[UIW-1:0];
      u_wd = uq;
    end
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      fmem[f_wa] <= f_wd;
    end
    fq <= fmem[f_ra];
  end

  always_ff @(posedge clk) begin
    if (u_we) begin
      umem[u_wa] <= u_wd;
    end
    uq <= umem[u_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fit_mode   <= FIT_FIRST;
      header     <= HDR_RESET;
      fcount     <= '0;
      ucount     <= '0;
      heap_top   <= '0;
      free_total <= '0;
      pend       <= 1'b0;
      found      <= 1'b0;
      spend      <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_FIT_MODE: fit_mode <= cfg_data[0];
          CFG_HEADER:   header   <= cfg_data;
          default:      header   <= header;
        endcase
      end

      if (cmd.load) begin
        func_r <= func;
        req    <= request_size;
        raddr  <= release_address;
      end

      if (cmd.rel_init) begin
        rstart <= W'(raddr) - hw;
      end

      if (cmd.scan_step) begin
        if (!scan_done && !idx_ge) begin
          scan_idx <= scan_idx + 1'b1;
          pend     <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
        case (cmd.scan_kind)
          SCAN_ALLOC: begin
            if (cand) begin
              found      <= 1'b1;
              cand_start <= qs;
              cand_len   <= ql;
              hit_idx    <= scan_prev;
            end
          end
          SCAN_USED: begin
            if (stop) begin
              found <= 1'b1;
              u_idx <= scan_prev[UIW-1:0];
              len_r <= ql;
            end
          end
          SCAN_FREE: begin
            if (!pend) begin
              hit_idx <= scan_idx;
            end else if (stop) begin
              found      <= 1'b1;
              cand_start <= qs;
              cand_len   <= ql;
              hit_idx    <= scan_prev;
            end else begin
              prev_start <= qs;
              prev_len   <= ql;
            end
          end
          default: found <= found;
        endcase
      end

      // A new scan may start in the cycle that ends the previous one.
      if (cmd.scan_init) begin
        scan_idx <= '0;
        pend     <= 1'b0;
        found    <= 1'b0;
      end

      if (cmd.grow) begin
        start_r  <= heap_top;
        len_r    <= A'(req);
        heap_top <= top_grow[A-1:0];
      end
      if (cmd.split) begin
        start_r    <= cand_start;
        len_r      <= A'(req);
        free_total <= ft_split[A-1:0];
      end
      if (cmd.take) begin
        start_r    <= cand_start;
        len_r      <= cand_len;
        free_total <= ft_take[A-1:0];
      end
      if (cmd.used_add) begin
        ucount <= ucount + 1'b1;
      end
      if (cmd.total_add) begin
        free_total <= ft_add[A-1:0];
      end

      if (cmd.dn_init) begin
        sidx  <= cmd.dn_used ? SW'(u_idx) : hit_idx;
        spend <= 1'b0;
      end
      if (cmd.up_init) begin
        sidx  <= SW'(fcount);
        spend <= 1'b0;
      end
      if (cmd.dn_step) begin
        sidx  <= dn_s2;
        spend <= dn_issue;
        if (!dn_issue) begin
          if (cmd.dn_used) begin
            ucount <= ucount - 1'b1;
          end else begin
            fcount <= fcount - 1'b1;
          end
        end
      end
      if (cmd.up_step) begin
        sidx  <= up_s2;
        spend <= up_issue;
      end
      if (cmd.ins) begin
        fcount <= fcount + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status       <= cmd.fin_status;
      data_address <= ((cmd.fin_status == ST_OK) && (func_r == FUNC_ALLOC)) ?
                      addr_wide[31:0] : 32'd0;
      heap_bytes   <= top_wide[31:0];
      free_bytes   <= total_wide[31:0];
    end
  end

  `HBA_ASSERT_NEXT(a_free_pop, cmd.dn_step && !cmd.dn_used && !dn_issue, fcount == $past(fcount) - 1'b1, "free count not decremented after removal")
  `HBA_ASSERT_NEXT(a_used_push, cmd.used_add, ucount == $past(ucount) + 1'b1, "used count not incremented after allocation")
  `HBA_ASSERT_NOW(a_used_room, cmd.used_add, ucount < UCW'(USED_ENTRIES), "allocation recorded into a full used table")

endmodule

`default_nettype wire

[hw/rtl/hba_ctrl.sv]
// Controller state machine of the heap block allocator.
// Drives hba_datapath through hba_pkg command and status structs.
`default_nettype none
`include "heap_block_allocator_assert.svh"

module hba_ctrl
  import hba_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      start,
  output logic           busy,
  output logic           done,
  output hba_cmd_t       cmd,
  input  wire hba_stat_t st
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHK       = 4'd1;
  localparam logic [3:0] S_ALC_SCAN  = 4'd2;
  localparam logic [3:0] S_ALC_DEC   = 4'd3;
  localparam logic [3:0] S_ALC_FDN   = 4'd4;
  localparam logic [3:0] S_ALC_USED  = 4'd5;
  localparam logic [3:0] S_REL_USCAN = 4'd6;
  localparam logic [3:0] S_REL_FSCAN = 4'd7;
  localparam logic [3:0] S_REL_MERGE = 4'd8;
  localparam logic [3:0] S_REL_FDN   = 4'd9;
  localparam logic [3:0] S_REL_FUP   = 4'd10;
  localparam logic [3:0] S_REL_INS   = 4'd11;
  localparam logic [3:0] S_REL_UREM  = 4'd12;
  localparam logic [3:0] S_REL_UDN   = 4'd13;
  localparam logic [3:0] S_REL_DONE  = 4'd14;

  logic [3:0] state, state_next;

  assign busy = state != S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (st.func == FUNC_RELEASE) begin
          if (st.hdr_over) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_UNKNOWN;
            state_next     = S_IDLE;
          end else begin
            cmd.rel_init  = 1'b1;
            cmd.scan_init = 1'b1;
            cmd.scan_kind = SCAN_USED;
            state_next    = S_REL_USCAN;
          end
        end else if (st.used_full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.scan_init = 1'b1;
          cmd.scan_kind = SCAN_ALLOC;
          state_next    = S_ALC_SCAN;
        end
      end
      S_ALC_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_kind = SCAN_ALLOC;
        if (st.scan_done) begin
          state_next = S_ALC_DEC;
        end
      end
      S_ALC_DEC: begin
        if (!st.found) begin
          if (st.overflow) begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_EXHAUSTED;
            state_next     = S_IDLE;
          end else begin
            cmd.grow   = 1'b1;
            state_next = S_ALC_USED;
          end
        end else if (st.split_fit) begin
          cmd.split  = 1'b1;
          state_next = S_ALC_USED;
        end else begin
          cmd.take    = 1'b1;
          cmd.dn_init = 1'b1;
          state_next  = S_ALC_FDN;
        end
      end
      S_ALC_FDN: begin
        cmd.dn_step = 1'b1;
        if (st.dn_last) begin
          state_next = S_ALC_USED;
        end
      end
      S_ALC_USED: begin
        cmd.used_add   = 1'b1;
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      S_REL_USCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_kind = SCAN_USED;
        if (st.scan_done) begin
          if (st.scan_stop) begin
            cmd.scan_init = 1'b1;
            state_next    = S_REL_FSCAN;
          end else begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_UNKNOWN;
            state_next     = S_IDLE;
          end
        end
      end
      S_REL_FSCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_kind = SCAN_FREE;
        if (st.scan_done) begin
          state_next = S_REL_MERGE;
        end
      end
      S_REL_MERGE: begin
        if (st.mp && st.mn) begin
          cmd.merge_write = 1'b1;
          cmd.dn_init     = 1'b1;
          state_next      = S_REL_FDN;
        end else if (st.mp || st.mn) begin
          cmd.merge_write = 1'b1;
          state_next      = S_REL_UREM;
        end else if (st.free_full) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_FULL;
          state_next     = S_IDLE;
        end else begin
          cmd.up_init = 1'b1;
          state_next  = S_REL_FUP;
        end
      end
      S_REL_FDN: begin
        cmd.dn_step = 1'b1;
        if (st.dn_last) begin
          state_next = S_REL_UREM;
        end
      end
      S_REL_FUP: begin
        cmd.up_step = 1'b1;
        if (st.up_last) begin
          state_next = S_REL_INS;
        end
      end
      S_REL_INS: begin
        cmd.ins    = 1'b1;
        state_next = S_REL_UREM;
      end
      S_REL_UREM: begin
        cmd.total_add = 1'b1;
        cmd.dn_init   = 1'b1;
        cmd.dn_used   = 1'b1;
        state_next    = S_REL_UDN;
      end
      S_REL_UDN: begin
        cmd.dn_step = 1'b1;
        cmd.dn_used = 1'b1;
        if (st.dn_last) begin
          state_next = S_REL_DONE;
        end
      end
      S_REL_DONE: begin
        cmd.finish     = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.finish;
    end
  end

  `HBA_ASSERT_NOW(a_done_idle, done, state == S_IDLE, "result strobe outside idle")
  `HBA_ASSERT_NEXT(a_accept_busy, (state == S_IDLE) && start, busy, "request accepted but not busy")
  `HBA_ASSERT_NOW(a_idle_quiet, (state == S_IDLE) && !start, cmd == '0, "command issued while idle")

endmodule

`default_nettype wire

[hw/rtl/heap_block_allocator.sv]
// Top level of the heap block allocator: controller plus datapath.
// Depends on hba_pkg, hba_ctrl and hba_datapath.
`default_nettype none

// A request is taken when start is high while busy is low; one result per
// request appears on data_address, status, heap_bytes and free_bytes for a
// single cycle while done is high, and the receiver cannot stall it, so it
// must capture the result in that cycle. One request is handled at a time.
// The tables sit in memories with one read and one write port and are walked
// one entry a cycle: an allocate scans the free table up to the fit point
// and shifts free entries when a free block is removed. A release scans the
// used table, scans the free table up to the release address, moves free
// entries on an insert or a double merge, and moves used entries on removal.
// Configuration writes are taken on any cycle with cfg_write high and should
// only be made while the block is idle.
module heap_block_allocator
  import hba_pkg::*;
#(
  parameter int FREE_ENTRIES = DEF_FREE_ENTRIES,
  parameter int USED_ENTRIES = DEF_USED_ENTRIES,
  parameter int ADDR_BITS    = DEF_ADDR_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        func,
  input  wire logic [31:0] request_size,
  input  wire logic [31:0] release_address,
  input  wire logic        cfg_write,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_data,
  output logic             done,
  output logic [31:0]      data_address,
  output logic [1:0]       status,
  output logic [31:0]      heap_bytes,
  output logic [31:0]      free_bytes
);

  hba_cmd_t  cmd;
  hba_stat_t st;

  hba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .st    (st)
  );

  hba_datapath #(
    .FREE_ENTRIES (FREE_ENTRIES),
    .USED_ENTRIES (USED_ENTRIES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .func            (func),
    .request_size    (request_size),
    .release_address (release_address),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .data_address    (data_address),
    .status          (status),
    .heap_bytes      (heap_bytes),
    .free_bytes      (free_bytes)
  );

endmodule

`default_nettype wire
